FILE: sv/sha1c_pkg.sv
// Shared types and constants for the SHA-1 block compression engine.
`timescale 1ns / 1ps

package sha1c_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic        new_message;
    } msg_beat_t;

    typedef struct packed {
        logic [31:0] digest_a;
        logic [31:0] digest_b;
        logic [31:0] digest_c;
        logic [31:0] digest_d;
        logic [31:0] digest_e;
    } dig_beat_t;

    typedef struct packed {
        logic [31:0] word;
        logic        restart;
        logic        last;
    } word_entry_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } back_state_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [31:0] INIT_E = 32'hC3D2E1F0;

    localparam logic [31:0] K_STAGE0 = 32'h5A827999;
    localparam logic [31:0] K_STAGE1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_STAGE2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_STAGE3 = 32'hCA62C1D6;

    localparam logic [3:0] LAST_SLOT  = 4'd15;
    localparam logic [6:0] LAST_ROUND = 7'd79;

endpackage

FILE: sv/sha1c_front.sv
// Front end: accepts message words and tags each with its block slot role.
`timescale 1ns / 1ps

module sha1c_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    output logic                   msg_stall,
    input  sha1c_pkg::msg_beat_t   msg,
    output logic                   push,
    output sha1c_pkg::word_entry_t entry,
    input  logic                   q_full
);
    import sha1c_pkg::*;

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [3:0] slot;

    assign msg_stall = q_full;
    assign push      = msg_valid && !q_full;
    assign slot      = msg.new_message ? 4'd0 : pos_reg;

    always_comb
    begin
        entry.word    = msg.message_word;
        entry.restart = msg.new_message;
        entry.last    = (slot == LAST_SLOT);
        pos_next      = push ? slot + 4'd1 : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: sv/sha1c_queue.sv
// Short word queue between the front end and the compression engine.
`timescale 1ns / 1ps

module sha1c_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sha1c_pkg::word_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output sha1c_pkg::word_entry_t head
);
    import sha1c_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    word_entry_t   slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_FULL))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count did not advance on push");

endmodule

FILE: sv/sha1c_back.sv
// Compression engine: loads the schedule window, runs 80 rounds, chains and emits the digest.
`timescale 1ns / 1ps

module sha1c_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  sha1c_pkg::word_entry_t head,
    output logic                   pop,
    output logic                   dig_valid,
    input  logic                   dig_stall,
    output sha1c_pkg::dig_beat_t   dig
);
    import sha1c_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    logic [6:0]  round_reg;
    logic [31:0] win_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] ha_reg, hb_reg, hc_reg, hd_reg, he_reg;
    logic        out_valid_reg;
    dig_beat_t   out_reg;

    logic        out_free;
    logic        do_load;
    logic        do_round;
    logic        do_finish;
    logic [31:0] sched_x;
    logic [31:0] w_new;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] na;

    assign out_free  = !out_valid_reg || !dig_stall;
    assign dig_valid = out_valid_reg;
    assign dig       = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (head_valid && head.last)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        do_load   = 1'b0;
        do_round  = 1'b0;
        do_finish = 1'b0;
        case (state_reg)
            ST_LOAD:   do_load   = head_valid;
            ST_ROUND:  do_round  = 1'b1;
            ST_FINISH: do_finish = out_free;
            default:   do_load   = 1'b0;
        endcase
        pop = do_load;
    end

    always_comb
    begin
        sched_x = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        if (round_reg < 7'd16)
        begin
            w_new = win_reg[0];
        end
        else
        begin
            w_new = {sched_x[30:0], sched_x[31]};
        end
        case (round_reg) inside
            [7'd0:7'd19]:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = K_STAGE0;
            end
            [7'd20:7'd39]:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K_STAGE1;
            end
            [7'd40:7'd59]:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = K_STAGE2;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K_STAGE3;
            end
        endcase
        na = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            round_reg     <= 7'd0;
            out_valid_reg <= 1'b0;
            ha_reg        <= INIT_A;
            hb_reg        <= INIT_B;
            hc_reg        <= INIT_C;
            hd_reg        <= INIT_D;
            he_reg        <= INIT_E;
        end
        else
        begin
            state_reg <= state_next;
            if (do_round)
            begin
                round_reg <= (round_reg == LAST_ROUND) ? 7'd0 : round_reg + 7'd1;
            end
            if (do_load && head.restart)
            begin
                ha_reg <= INIT_A;
                hb_reg <= INIT_B;
                hc_reg <= INIT_C;
                hd_reg <= INIT_D;
                he_reg <= INIT_E;
            end
            else if (do_finish)
            begin
                ha_reg <= ha_reg + a_reg;
                hb_reg <= hb_reg + b_reg;
                hc_reg <= hc_reg + c_reg;
                hd_reg <= hd_reg + d_reg;
                he_reg <= he_reg + e_reg;
            end
            if (do_finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!dig_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= head.word;
        end
        else if (do_round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_new;
        end
        if (do_load && head.last)
        begin
            a_reg <= ha_reg;
            b_reg <= hb_reg;
            c_reg <= hc_reg;
            d_reg <= hd_reg;
            e_reg <= he_reg;
        end
        else if (do_round)
        begin
            a_reg <= na;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (do_finish)
        begin
            out_reg.digest_a <= ha_reg + a_reg;
            out_reg.digest_b <= hb_reg + b_reg;
            out_reg.digest_c <= hc_reg + c_reg;
            out_reg.digest_d <= hd_reg + d_reg;
            out_reg.digest_e <= he_reg + e_reg;
        end
    end

    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ROUND) |-> (round_reg == 7'd0))
        else $error("round counter active outside the round phase");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == LAST_ROUND) |=> (state_reg == ST_FINISH))
        else $error("round phase did not end after the last round");

    a_digest_out: assert property (@(posedge clk) disable iff (!rst_n)
        do_finish |=> (dig_valid && state_reg == ST_LOAD))
        else $error("finished block did not present a digest");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !pop)
        else $error("word taken from queue while compressing");

endmodule

FILE: sv/sha1_block_compression_top.sv
// Top level of the SHA-1 block compression engine.
`timescale 1ns / 1ps

// Feed a padded message as 32-bit big-endian words, sixteen to a block; set
// new_message on the first word of a message to restart from the standard
// initial value (a partly collected block is then dropped). Each completed
// block yields one beat carrying the chained 160-bit value A..E; other words
// yield nothing. A block moves its words into the schedule window, runs its
// 80 rounds in the single round unit (one round per cycle), then takes the
// chaining add, which waits while the output register holds a stalled digest.
// A queue of QUEUE_DEPTH words takes input while the rounds run until it is
// full, and the digest waits in an output register as the next block loads.
module sha1_block_compression_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 msg_valid,
    output logic                 msg_stall,
    input  sha1c_pkg::msg_beat_t msg,
    output logic                 dig_valid,
    input  logic                 dig_stall,
    output sha1c_pkg::dig_beat_t dig
);
    import sha1c_pkg::*;

    logic        push;
    logic        q_full;
    logic        pop;
    logic        head_valid;
    word_entry_t push_entry;
    word_entry_t head;

    sha1c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .push      (push),
        .entry     (push_entry),
        .q_full    (q_full)
    );

    sha1c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sha1c_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .dig_valid  (dig_valid),
        .dig_stall  (dig_stall),
        .dig        (dig)
    );

endmodule

FILE: tb/sha1_block_compression_top_test.sv
// Self-checking testbench for the SHA-1 block compression engine.
`timescale 1ns / 1ps

module sha1_block_compression_top_test;
    import sha1c_pkg::*;

    localparam int WORD_COUNT  = 1500;
    localparam int CALM_WORDS  = 150;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 200;
    localparam int BLOCK_WORDS = 16;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      msg_valid = 1'b0;
    logic      msg_stall;
    msg_beat_t msg       = '0;
    logic      dig_valid;
    logic      dig_stall = 1'b0;
    dig_beat_t dig;

    msg_beat_t   word_q[$];
    dig_beat_t   digest_q[$];
    logic [31:0] chain_val [5];
    logic [31:0] sched [16];
    logic [3:0]  slot;
    int          err_count  = 0;
    int          idle_count = 0;
    int          cyc        = 0;
    int          in_rate    = 0;
    int          out_rate   = 0;
    int          gap_left   = 0;
    int          stall_left = 0;

    sha1_block_compression_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        err_count++;
    endtask

    // fold one accepted word into the chaining state; a full block yields a digest
    task automatic absorb_word(input msg_beat_t beat);
        logic [31:0] ra, rb, rc, rd, re, w, f, k, na;
        logic [3:0]  ti;
        dig_beat_t   digest;
        if (beat.new_message)
        begin
            chain_val = '{INIT_A, INIT_B, INIT_C, INIT_D, INIT_E};
            slot = '0;
        end
        sched[slot] = beat.message_word;
        if (slot != LAST_SLOT)
        begin
            slot = slot + 4'd1;
            return;
        end
        slot = '0;
        ra = chain_val[0];
        rb = chain_val[1];
        rc = chain_val[2];
        rd = chain_val[3];
        re = chain_val[4];
        for (int t = 0; t < 80; t++)
        begin
            ti = t[3:0];
            if (t >= 16)
            begin
                w = sched[ti - 4'd3] ^ sched[ti - 4'd8] ^ sched[ti - 4'd14] ^ sched[ti];
                w = {w[30:0], w[31]};
                sched[ti] = w;
            end
            else
                w = sched[ti];
            if (t < 20)
            begin
                f = (rb & rc) | (~rb & rd);
                k = K_STAGE0;
            end
            else if (t < 40)
            begin
                f = rb ^ rc ^ rd;
                k = K_STAGE1;
            end
            else if (t < 60)
            begin
                f = (rb & rc) | (rb & rd) | (rc & rd);
                k = K_STAGE2;
            end
            else
            begin
                f = rb ^ rc ^ rd;
                k = K_STAGE3;
            end
            na = {ra[26:0], ra[31:27]} + f + re + k + w;
            re = rd;
            rd = rc;
            rc = {rb[1:0], rb[31:2]};
            rb = ra;
            ra = na;
        end
        chain_val[0] = chain_val[0] + ra;
        chain_val[1] = chain_val[1] + rb;
        chain_val[2] = chain_val[2] + rc;
        chain_val[3] = chain_val[3] + rd;
        chain_val[4] = chain_val[4] + re;
        digest.digest_a = chain_val[0];
        digest.digest_b = chain_val[1];
        digest.digest_c = chain_val[2];
        digest.digest_d = chain_val[3];
        digest.digest_e = chain_val[4];
        digest_q.push_back(digest);
    endtask

    task automatic check_digest(input dig_beat_t got);
        string     names [5] = '{"digest_a", "digest_b", "digest_c", "digest_d", "digest_e"};
        dig_beat_t want;
        if (digest_q.size() == 0)
        begin
            report_mismatch($sformatf("digest beat with none pending: %h", got));
            return;
        end
        want = digest_q.pop_front();
        for (int i = 0; i < 5; i++)
            if (got[159 - 32 * i -: 32] !== want[159 - 32 * i -: 32])
                report_mismatch($sformatf("%s got %h want %h", names[i],
                                          got[159 - 32 * i -: 32],
                                          want[159 - 32 * i -: 32]));
    endtask

    task automatic push_word(input logic [31:0] value, input logic first);
        msg_beat_t beat;
        beat.message_word = value;
        beat.new_message  = first;
        word_q.push_back(beat);
    endtask

    function automatic logic [31:0] pick_word();
        int sel;
        sel = $urandom_range(15);
        if (sel == 0)
            return 32'h0000_0000;
        if (sel == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic bit calm();
        return word_q.size() < CALM_WORDS;
    endfunction

    // driver: hold a stalled beat, otherwise idle in bursts or present the next word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid <= 1'b0;
            msg       <= '0;
            gap_left  <= 0;
            in_rate   <= 0;
        end
        else
        begin
            if (msg_valid && !msg_stall)
                absorb_word(msg);
            if (cyc % 300 == 0)
                in_rate <= $urandom_range(3) * 12;
            if (!(msg_valid && msg_stall))
            begin
                if (gap_left != 0)
                begin
                    gap_left  <= gap_left - 1;
                    msg_valid <= 1'b0;
                end
                else if (!calm() && $urandom_range(99) < in_rate)
                begin
                    gap_left  <= $urandom_range(5);
                    msg_valid <= 1'b0;
                end
                else if (word_q.size() != 0)
                begin
                    msg       <= word_q.pop_front();
                    msg_valid <= 1'b1;
                end
                else
                    msg_valid <= 1'b0;
            end
        end
    end

    // monitor: check digest beats and stall the output side in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_stall  <= 1'b0;
            stall_left <= 0;
            out_rate   <= 0;
        end
        else
        begin
            if (dig_valid && !dig_stall)
                check_digest(dig);
            if (cyc % 250 == 0)
                out_rate <= $urandom_range(3) * 12;
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                dig_stall  <= 1'b1;
            end
            else if (!calm() && $urandom_range(99) < out_rate)
            begin
                stall_left <= $urandom_range(5);
                dig_stall  <= 1'b1;
            end
            else
                dig_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (!rst_n || (msg_valid && !msg_stall) || (dig_valid && !dig_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int sel;
        int blocks;
        int part;
        chain_val = '{INIT_A, INIT_B, INIT_C, INIT_D, INIT_E};
        slot = '0;
        foreach (sched[i])
            sched[i] = '0;

        // no flag after reset: chain from the initial value
        for (int i = 0; i < BLOCK_WORDS; i++)
            push_word(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, 1'b0);
        // partial block, then a flag mid-block drops it
        push_word(32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < 4; i++)
            push_word(32'h8000_0001 << i, 1'b0);
        push_word(32'h0000_0000, 1'b1);

        while (word_q.size() < WORD_COUNT)
        begin
            sel = $urandom_range(99);
            if (sel < 75)
            begin
                blocks = $urandom_range(1, 3);
                for (int b = 0; b < blocks; b++)
                    for (int i = 0; i < BLOCK_WORDS; i++)
                        push_word(pick_word(), (b == 0) && (i == 0));
            end
            else if (sel < 88)
            begin
                for (int i = 0; i < BLOCK_WORDS; i++)
                    push_word(pick_word(), 1'b0);
            end
            else
            begin
                part = $urandom_range(1, BLOCK_WORDS - 1);
                for (int i = 0; i < part; i++)
                    push_word(pick_word(), (i == 0) || ($urandom_range(7) == 0));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (word_q.size() != 0 || msg_valid || digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (digest_q.size() != 0)
            report_mismatch($sformatf("%0d digest beats never arrived", digest_q.size()));
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
